// ===== rtl/core/kis_pkg.sv =====
// Shared types, widths and constants for the key frame interval search block.
`timescale 1ns / 1ps

package kis_pkg;

   localparam int MAX_KEYS_DEFAULT = 1024;

   localparam int KEY_INDEX_W  = 10;
   localparam int KEY_FRAME_W  = 16;
   localparam int QUERY_TIME_W = 32;
   localparam int KEY_COUNT_W  = 11;
   localparam int FPS_W        = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int SCALED_W     = QUERY_TIME_W + FPS_W;
   localparam int RATIO_W      = 17;
   localparam int STATUS_W     = 2;

   // key positions are frame << 24, so the widest difference fits in 40 bits
   localparam int POS_SHIFT    = 24;
   localparam int POS_W        = KEY_FRAME_W + POS_SHIFT;
   localparam int DIV_STEPS    = RATIO_W;
   localparam int DIV_STEP_W   = $clog2(DIV_STEPS);

   localparam logic [FPS_W-1:0]       FPS_RESET = 16'd7680;
   localparam logic [RATIO_W-1:0]     RATIO_ONE = 17'd65536;

   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_KEY_COUNT         = 1'b0,
      REG_FRAMES_PER_SECOND = 1'b1
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_EMPTY       = 2'd1,
      STATUS_NO_INTERVAL = 2'd2
   } status_type;

   typedef struct packed {
      logic                    is_query;
      logic [KEY_INDEX_W-1:0]  key_index;
      logic [KEY_FRAME_W-1:0]  key_frame;
      logic [SCALED_W-1:0]     scaled_time;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

endpackage

// ===== rtl/core/kis_stream_if.sv =====
// Request and response channel interfaces of the key frame interval search block.
`timescale 1ns / 1ps

interface kis_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [kis_pkg::KEY_INDEX_W-1:0]     key_index;
   logic [kis_pkg::KEY_FRAME_W-1:0]     key_frame;
   logic [kis_pkg::QUERY_TIME_W-1:0]    query_time;

   modport source (output valid, req_type, key_index, key_frame, query_time, input ready);
   modport sink   (input valid, req_type, key_index, key_frame, query_time, output ready);
endinterface

interface kis_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [kis_pkg::KEY_INDEX_W-1:0]     first_key;
   logic [kis_pkg::KEY_INDEX_W-1:0]     second_key;
   logic [kis_pkg::RATIO_W-1:0]         interp_ratio;
   logic [kis_pkg::STATUS_W-1:0]        status;

   modport source (output valid, first_key, second_key, interp_ratio, status, input ready);
   modport sink   (input valid, first_key, second_key, interp_ratio, status, output ready);
endinterface

// ===== rtl/core/kis_front.sv =====
// Front end: configuration registers, request intake and time scaling.
`timescale 1ns / 1ps

module kis_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [kis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kis_pkg::CSR_DATA_W-1:0]      csr_write_data,
   kis_req_if.sink                             req_if,
   input  logic                                push_ready,
   output kis_pkg::queue_head_type             push,
   output logic [kis_pkg::KEY_COUNT_W-1:0]     key_count
);

   logic [kis_pkg::KEY_COUNT_W-1:0] key_count_ff;
   logic [kis_pkg::FPS_W-1:0]       fps_ff;
   logic [kis_pkg::SCALED_W-1:0]    scaled_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
         fps_ff       <= kis_pkg::FPS_RESET;
      end else if (csr_write_enable) begin
         unique case (kis_pkg::reg_index_type'(csr_index))
            kis_pkg::REG_KEY_COUNT: begin
               key_count_ff <= csr_write_data[kis_pkg::KEY_COUNT_W-1:0];
            end
            kis_pkg::REG_FRAMES_PER_SECOND: begin
               fps_ff <= csr_write_data[kis_pkg::FPS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Q16.16 seconds times Q8.8 fps gives frames in Q.24; the queue registers it
   always_comb begin
      scaled_time = kis_pkg::SCALED_W'(req_if.query_time) * kis_pkg::SCALED_W'(fps_ff);
   end

   assign req_if.ready               = push_ready;
   assign push.valid                 = req_if.valid;
   assign push.entry.is_query        = req_if.req_type;
   assign push.entry.key_index       = req_if.key_index;
   assign push.entry.key_frame       = req_if.key_frame;
   assign push.entry.scaled_time     = scaled_time;
   assign key_count                  = key_count_ff;

endmodule

// ===== rtl/core/kis_queue.sv =====
// Short queue between the front end and the search engine.
`timescale 1ns / 1ps

module kis_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  kis_pkg::queue_head_type   push,
   output logic                      push_ready,
   output kis_pkg::queue_head_type   head,
   input  logic                      pop
);

   localparam int DEPTH = kis_pkg::QUEUE_DEPTH;

   kis_pkg::queue_entry_type                slot_ff [DEPTH];
   logic [kis_pkg::QUEUE_PTR_W-1:0]        wr_ptr_ff;
   logic [kis_pkg::QUEUE_PTR_W-1:0]        rd_ptr_ff;
   logic [kis_pkg::QUEUE_CNT_W-1:0]        count_ff;
   logic                                   do_push;
   logic                                   do_pop;

   assign push_ready = (count_ff != kis_pkg::QUEUE_CNT_W'(DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == kis_pkg::QUEUE_PTR_W'(DEPTH - 1)) ? '0
                                                                         : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == kis_pkg::QUEUE_PTR_W'(DEPTH - 1)) ? '0
                                                                         : rd_ptr_ff + 1'b1;
         end
         priority if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== rtl/core/kis_back.sv =====
// Back end: key table, linear interval search and ratio divider.
`timescale 1ns / 1ps

module kis_back #(
   parameter int MAX_KEYS = kis_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [kis_pkg::KEY_COUNT_W-1:0]     key_count,
   input  kis_pkg::queue_head_type             head,
   output logic                                pop,
   kis_rsp_if.source                           rsp_if
);

   localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int KW    = kis_pkg::KEY_FRAME_W;
   localparam int PW    = kis_pkg::POS_W;
   localparam int SW    = kis_pkg::SCALED_W;
   localparam int XW    = kis_pkg::KEY_INDEX_W;

   typedef enum logic [2:0] {
      IDLE,
      CHECK_FIRST,
      CHECK_LAST,
      SCAN,
      DIVIDE,
      RESPOND
   } state_type;

   function automatic logic [XW-1:0] to_key(input logic [CNT_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[XW-1:0];
   endfunction

   logic [KW-1:0]                 mem [MAX_KEYS];
   logic [KW-1:0]                 rd_data_ff;
   logic [IDX_W-1:0]              rd_addr;
   logic                          mem_we;
   logic [IDX_W-1:0]              wr_addr;
   logic [31:0]                   wr_index_wide;

   state_type                     state_ff;
   logic [SW-1:0]                 time_ff;
   logic [KW-1:0]                 lo_ff;
   logic [CNT_W-1:0]              scan_idx_ff;
   logic [PW-1:0]                 rem_ff;
   logic [PW-1:0]                 dvs_ff;
   logic [kis_pkg::RATIO_W-1:0]   quo_ff;
   logic [kis_pkg::DIV_STEP_W-1:0] step_ff;
   logic [XW-1:0]                 first_ff;
   logic [XW-1:0]                 second_ff;
   logic [kis_pkg::RATIO_W-1:0]   ratio_ff;
   kis_pkg::status_type           status_ff;

   logic [31:0]                   n_wide;
   logic [CNT_W-1:0]              n;
   logic [CNT_W-1:0]              n_m1;
   logic [CNT_W-1:0]              n_m2;
   logic [CNT_W-1:0]              scan_next;
   logic [CNT_W-1:0]              scan_prev;
   logic [SW-1:0]                 rd_pos;
   logic [SW-1:0]                 lo_pos;
   logic [SW-1:0]                 diff;
   logic                          in_interval;
   logic                          rem_ge;
   logic [kis_pkg::RATIO_W-1:0]   quo_next;

   // a count above the table size acts as the table size
   assign n_wide    = (32'(key_count) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(key_count);
   assign n         = n_wide[CNT_W-1:0];
   assign n_m1      = n - CNT_W'(1);
   assign n_m2      = n - CNT_W'(2);
   assign scan_next = scan_idx_ff + CNT_W'(1);
   assign scan_prev = scan_idx_ff - CNT_W'(1);

   assign rd_pos      = SW'({rd_data_ff, {kis_pkg::POS_SHIFT{1'b0}}});
   assign lo_pos      = SW'({lo_ff, {kis_pkg::POS_SHIFT{1'b0}}});
   assign diff        = time_ff - lo_pos;
   assign in_interval = (time_ff >= lo_pos) && (rd_pos >= time_ff);

   assign rem_ge   = (rem_ff >= dvs_ff);
   assign quo_next = {quo_ff[kis_pkg::RATIO_W-2:0], rem_ge};

   assign wr_index_wide = 32'(head.entry.key_index);
   assign wr_addr       = wr_index_wide[IDX_W-1:0];
   assign pop           = (state_ff == IDLE) && head.valid;
   assign mem_we        = pop && !head.entry.is_query && (wr_index_wide < 32'(MAX_KEYS));

   always_comb begin
      unique case (state_ff)
         CHECK_FIRST: rd_addr = n_m1[IDX_W-1:0];
         CHECK_LAST:  rd_addr = IDX_W'(1);
         SCAN:        rd_addr = scan_next[IDX_W-1:0];
         default:     rd_addr = '0;
      endcase
   end

   // read data is registered, so it lines up with the address issued in the cycle before
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= head.entry.key_frame;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (pop && head.entry.is_query) begin
                  time_ff   <= head.entry.scaled_time;
                  first_ff  <= '0;
                  second_ff <= '0;
                  ratio_ff  <= '0;
                  priority if (n == '0) begin
                     status_ff <= kis_pkg::STATUS_EMPTY;
                     state_ff  <= RESPOND;
                  end else if (n == CNT_W'(1)) begin
                     status_ff <= kis_pkg::STATUS_OK;
                     state_ff  <= RESPOND;
                  end else begin
                     status_ff <= kis_pkg::STATUS_OK;
                     state_ff  <= CHECK_FIRST;
                  end
               end
            end
            CHECK_FIRST: begin
               lo_ff <= rd_data_ff;
               if (rd_pos > time_ff) begin
                  second_ff <= XW'(1);
                  state_ff  <= RESPOND;
               end else begin
                  state_ff <= CHECK_LAST;
               end
            end
            CHECK_LAST: begin
               scan_idx_ff <= CNT_W'(1);
               if (time_ff > rd_pos) begin
                  first_ff  <= to_key(n_m2);
                  second_ff <= to_key(n_m1);
                  ratio_ff  <= kis_pkg::RATIO_ONE;
                  state_ff  <= RESPOND;
               end else begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               lo_ff       <= rd_data_ff;
               scan_idx_ff <= scan_next;
               priority if (in_interval) begin
                  first_ff  <= to_key(scan_prev);
                  second_ff <= to_key(scan_idx_ff);
                  // ratio = (t - lo) / ((hi - lo) << 8), one quotient bit a step
                  rem_ff    <= diff[PW-1:0];
                  dvs_ff    <= {rd_data_ff - lo_ff, {kis_pkg::POS_SHIFT{1'b0}}};
                  quo_ff    <= '0;
                  step_ff   <= '0;
                  state_ff  <= (rd_data_ff > lo_ff) ? DIVIDE : RESPOND;
               end else if (scan_idx_ff == n_m1) begin
                  status_ff <= kis_pkg::STATUS_NO_INTERVAL;
                  state_ff  <= RESPOND;
               end
            end
            DIVIDE: begin
               if (rem_ge) begin
                  rem_ff <= rem_ff - dvs_ff;
               end
               dvs_ff  <= dvs_ff >> 1;
               quo_ff  <= quo_next;
               step_ff <= step_ff + 1'b1;
               if (step_ff == kis_pkg::DIV_STEP_W'(kis_pkg::DIV_STEPS - 1)) begin
                  ratio_ff <= quo_next;
                  state_ff <= RESPOND;
               end
            end
            RESPOND: begin
               if (rsp_if.ready) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_if.valid        = (state_ff == RESPOND);
   assign rsp_if.first_key    = first_ff;
   assign rsp_if.second_key   = second_ff;
   assign rsp_if.interp_ratio = ratio_ff;
   assign rsp_if.status       = status_ff;

endmodule

// ===== rtl/core/keyframe_interval_search.sv =====
// Top level of the key frame interval search block.
//
//   channel   direction  transaction
//   req_if    in         key load (req_type 0) or time query (req_type 1)
//   rsp_if    out        bracketing keys, ratio and status, one per query
//   csr_*     in         register write: key_count, frames_per_second
//
// A load writes the key table as the engine pops it. A query runs a linear
// scan over the n keys of the key count (one table read a cycle), then the
// restoring ratio divider.
// Synchronous reset clears control only; the key table is not cleared.
// The front end keeps taking transactions into a two-entry queue while a
// response waits, and stalls only when that queue is full.
`timescale 1ns / 1ps

module keyframe_interval_search #(
   parameter int MAX_KEYS = kis_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   kis_req_if.sink                             req_if,
   kis_rsp_if.source                           rsp_if,
   input  logic                                csr_write_enable,
   input  logic [kis_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kis_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   kis_pkg::queue_head_type           push;
   kis_pkg::queue_head_type           head;
   logic                              push_ready;
   logic                              pop;
   logic [kis_pkg::KEY_COUNT_W-1:0]   key_count;

   kis_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req_if),
      .push_ready       (push_ready),
      .push             (push),
      .key_count        (key_count)
   );

   kis_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   kis_back #(
      .MAX_KEYS (MAX_KEYS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .key_count (key_count),
      .head      (head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule
